// ===== src/pq_pkg.sv =====
package pq_pkg;

  localparam int CAPACITY_DEFAULT    = 1024;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int DATA_WIDTH          = 32;
  localparam int STATUS_WIDTH        = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_LOAD,
    ST_DOWN,
    ST_UP_START,
    ST_UP,
    ST_RESP
  } eng_state_t;

  typedef struct packed {
    op_t                           op;
    logic signed [DATA_WIDTH-1:0]  value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  min_value;
    status_t                       status;
  } rsp_word_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

endpackage

// ===== src/pq_cmd_if.sv =====
interface pq_cmd_if;
  import pq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [DATA_WIDTH-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// ===== src/pq_rsp_if.sv =====
interface pq_rsp_if;
  import pq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  min_value;
  logic [STATUS_WIDTH-1:0]       status;

  modport source (output valid, output min_value, output status, input ready);
  modport sink (input valid, input min_value, input status, output ready);
endinterface

// ===== src/pq_heap_mem.sv =====
module pq_heap_mem #(
  parameter int DEPTH = pq_pkg::CAPACITY_DEFAULT,
  parameter int WIDTH = pq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== src/pq_engine.sv =====
module pq_engine #(
  parameter int CAPACITY    = pq_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = pq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  pq_pkg::cmd_word_t           cmd_word,
  input  logic                        res_take,
  output pq_pkg::eng_status_t         eng_status,
  output pq_pkg::rsp_word_t           res_word,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [VALUE_WIDTH-1:0]      mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr0,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr1,
  input  logic [VALUE_WIDTH-1:0]      mem_rdata0,
  input  logic [VALUE_WIDTH-1:0]      mem_rdata1
);
  import pq_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = CNT_W + 1;

  function automatic logic signed [VALUE_WIDTH-1:0] to_entry(logic signed [DATA_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] from_entry(logic signed [VALUE_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  eng_state_t                     state, state_next;
  logic [CNT_W-1:0]               count, count_next;
  logic [IDX_W-1:0]               pos, pos_next;
  logic signed [VALUE_WIDTH-1:0]  hold, hold_next;
  logic signed [DATA_WIDTH-1:0]   res_min, res_min_next;
  status_t                        res_status, res_status_next;

  logic signed [VALUE_WIDTH-1:0]  rd0, rd1;
  logic [IDX_W-1:0]               parent_pos, grand_pos;
  logic [CHILD_W-1:0]             left_idx, right_idx, best_idx, best_left;
  logic                           left_ok, right_ok, pick_right, move_down;
  logic signed [VALUE_WIDTH-1:0]  best_val;
  logic [CNT_W-1:0]               count_dec;

  assign rd0        = mem_rdata0;
  assign rd1        = mem_rdata1;
  assign parent_pos = (pos - IDX_W'(1)) >> 1;
  assign grand_pos  = (parent_pos - IDX_W'(1)) >> 1;
  assign left_idx   = (CHILD_W'(pos) << 1) + CHILD_W'(1);
  assign right_idx  = left_idx + CHILD_W'(1);
  assign left_ok    = left_idx < CHILD_W'(count);
  assign right_ok   = right_idx < CHILD_W'(count);
  assign pick_right = right_ok && (rd1 < rd0);
  assign best_val   = pick_right ? rd1 : rd0;
  assign best_idx   = pick_right ? right_idx : left_idx;
  assign best_left  = (best_idx << 1) + CHILD_W'(1);
  assign move_down  = left_ok && (best_val < hold);
  assign count_dec  = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    hold       <= hold_next;
    res_min    <= res_min_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    hold_next       = hold;
    res_min_next    = res_min;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = pos;
    mem_wdata       = hold;
    mem_raddr0      = '0;
    mem_raddr1      = '0;
    eng_status.idle      = 1'b0;
    eng_status.res_valid = 1'b0;

    case (state)
      ST_IDLE: begin
        eng_status.idle = 1'b1;
        if (start) begin
          res_min_next    = '0;
          res_status_next = STATUS_OK;
          if (cmd_word.op == OP_INSERT) begin
            if (count >= CNT_W'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_RESP;
            end else begin
              hold_next  = to_entry(cmd_word.value);
              pos_next   = count[IDX_W-1:0];
              count_next = count + CNT_W'(1);
              state_next = ST_UP_START;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = ST_RESP;
            end else begin
              mem_raddr0 = '0;
              mem_raddr1 = count_dec[IDX_W-1:0];
              state_next = ST_POP_LOAD;
            end
          end
        end
      end
      ST_POP_LOAD: begin
        res_min_next = from_entry(rd0);
        count_next   = count_dec;
        if (count_dec == '0) begin
          state_next = ST_RESP;
        end else begin
          hold_next  = rd1;
          pos_next   = '0;
          mem_raddr0 = IDX_W'(1);
          mem_raddr1 = IDX_W'(2);
          state_next = ST_DOWN;
        end
      end
      ST_DOWN: begin
        mem_we = 1'b1;
        if (move_down) begin
          mem_wdata  = best_val;
          pos_next   = best_idx[IDX_W-1:0];
          mem_raddr0 = best_left[IDX_W-1:0];
          mem_raddr1 = best_left[IDX_W-1:0] + IDX_W'(1);
        end else begin
          mem_wdata  = hold;
          state_next = ST_RESP;
        end
      end
      ST_UP_START: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          mem_wdata  = hold;
          state_next = ST_RESP;
        end else begin
          mem_raddr0 = parent_pos;
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        mem_we = 1'b1;
        if (hold < rd0) begin
          mem_wdata = rd0;
          pos_next  = parent_pos;
          if (parent_pos == '0) begin
            state_next = ST_UP_START;
          end else begin
            mem_raddr0 = grand_pos;
          end
        end else begin
          mem_wdata  = hold;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        eng_status.res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res_word.min_value = res_min;
  assign res_word.status    = res_status;

endmodule

// ===== src/min_priority_queue_core.sv =====
// Channel  Dir  Word
// cmd      in   op (0 insert, 1 pop), value
// rsp      out  min_value, status (0 ok, 1 empty, 2 full)
//
// An insert starts the new entry at the end of the heap and moves it up one level per step.
// A pop reads the root and the last entry, then sinks the moved entry one level per
// step, as both children are read together. An insert into an empty queue or a pop
// of the last entry moves nothing, and rejected words go straight to the response.
// Reset clears the entry count, the engine state and the output valid flag; the heap memory needs no clearing.
// One word is in work at a time; a finished word waits in the output register, and
// while that register is held the engine waits and the input is not ready.
module min_priority_queue_core #(
  parameter int CAPACITY    = pq_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = pq_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  pq_cmd_if.sink  cmd,
  pq_rsp_if.source rsp
);
  import pq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  cmd_word_t               cmd_word;
  rsp_word_t               res_word;
  eng_status_t             eng_status;
  logic                    start, res_take;
  logic                    out_valid;
  rsp_word_t               out_word;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr0, mem_raddr1;
  logic [VALUE_WIDTH-1:0]  mem_wdata, mem_rdata0, mem_rdata1;

  assign cmd_word.op    = op_t'(cmd.op);
  assign cmd_word.value = cmd.value;
  assign cmd.ready      = eng_status.idle;
  assign start          = cmd.valid && eng_status.idle;
  assign res_take       = eng_status.res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res_word;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.min_value = out_word.min_value;
  assign rsp.status    = out_word.status;

  pq_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd_word   (cmd_word),
    .res_take   (res_take),
    .eng_status (eng_status),
    .res_word   (res_word),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .mem_rdata0 (mem_rdata0),
    .mem_rdata1 (mem_rdata1)
  );

  pq_heap_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_heap_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

endmodule

// ===== src/pq_checker.sv =====
module pq_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     cmd_valid,
  input logic                                     cmd_ready,
  input logic                                     rsp_valid,
  input logic                                     rsp_ready,
  input logic signed [pq_pkg::DATA_WIDTH-1:0]     rsp_min_value,
  input logic [pq_pkg::STATUS_WIDTH-1:0]          rsp_status
);
  import pq_pkg::*;

  property p_rsp_hold;
    @(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_value) && $stable(rsp_status);
  endproperty
  a_rsp_hold: assert property (p_rsp_hold) else $error("response word changed while stalled");

  property p_error_zero;
    @(posedge clk) disable iff (rst)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_min_value == '0;
  endproperty
  a_error_zero: assert property (p_error_zero) else $error("rejected word carries a value");

  property p_busy_after_accept;
    @(posedge clk) disable iff (rst)
      cmd_valid && cmd_ready |=> !cmd_ready;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("command accepted on consecutive cycles");

  property p_reset_clears;
    @(posedge clk) rst |=> !rsp_valid && cmd_ready;
  endproperty
  a_reset_clears: assert property (p_reset_clears) else $error("reset left the queue busy");

endmodule

bind min_priority_queue_core pq_checker u_pq_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_min_value (rsp.min_value),
  .rsp_status    (rsp.status)
);

// ===== sim/pq_order_checker.sv =====
`timescale 1ns / 100ps

module pq_order_checker #(
  parameter int CAPACITY    = pq_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = pq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  pq_cmd_if    cmd,
  pq_rsp_if    rsp,
  output int   fail_count,
  output int   pending_rsp
);
  import pq_pkg::*;

  // Stored values are kept in ascending order, so a pop takes the front.
  logic signed [DATA_WIDTH-1:0] held_values[$];
  rsp_word_t                    due_rsp[$];
  int                           miss_count = 0;
  int                           rsp_count = 0;

  function automatic rsp_word_t predict_word(op_t op, logic signed [DATA_WIDTH-1:0] val);
    rsp_word_t                     r;
    logic signed [VALUE_WIDTH-1:0] narrow;
    logic signed [DATA_WIDTH-1:0]  wide;
    int                            pos;
    r.min_value = '0;
    r.status    = STATUS_OK;
    if (op == OP_INSERT) begin
      if (held_values.size() >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        narrow = val[VALUE_WIDTH-1:0];
        wide   = DATA_WIDTH'(narrow);
        pos    = 0;
        while (pos < held_values.size() && held_values[pos] <= wide) pos++;
        held_values.insert(pos, wide);
      end
    end else if (held_values.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.min_value = held_values.pop_front();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      held_values.delete();
      due_rsp.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        due_rsp = {due_rsp, predict_word(op_t'(cmd.op), cmd.value)};
      end
      if (rsp.valid && rsp.ready) begin
        rsp_count++;
        if (due_rsp.size() == 0) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("rsp word %0d arrived with none due: min_value %0d status %0d",
                     rsp_count, rsp.min_value, rsp.status);
          end
        end else begin
          want = due_rsp.pop_front();
          if (want.min_value !== rsp.min_value || want.status !== rsp.status) begin
            miss_count++;
            if (miss_count <= 10) begin
              $display("rsp word %0d: min_value expected %0d got %0d, status expected %0d got %0d",
                       rsp_count, want.min_value, rsp.min_value, want.status, rsp.status);
            end
          end
        end
      end
    end
    fail_count  <= miss_count;
    pending_rsp <= due_rsp.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pq_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEFAULT;
  localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
  localparam int LIMIT       = 600000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending_rsp;
  int   cycle_count = 0;
  int   burst_left = 0;

  pq_cmd_if cmd_ch();
  pq_rsp_if rsp_ch();

  min_priority_queue_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  pq_order_checker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) checker_inst (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .pending_rsp (pending_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("min_priority_queue_core regression: fail");
      $finish;
    end
  end

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return DATA_WIDTH'($urandom_range(0, 16)) - 8;
    if (sel == 8) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  task automatic send_word(input op_t op, input logic signed [DATA_WIDTH-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.op    <= op;
    cmd_ch.value <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic run_mixed(input int count, input int insert_pct);
    repeat (count) begin
      send_word(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP, pick_value());
    end
  endtask

  initial begin
    int mode;
    int seg_len;
    int cyc;
    bit held_off;
    rsp_ch.ready <= 1'b0;
    cyc      = 0;
    held_off = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 150);
      repeat (seg_len) begin
        @(posedge clk);
        cyc++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      if (!held_off && cyc > 2500) begin
        held_off = 1'b1;
        @(posedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.op    <= OP_INSERT;
    cmd_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_POP, 32'sh0);
    send_word(OP_INSERT, 32'sh0);
    send_word(OP_INSERT, 32'sh7fffffff);
    send_word(OP_INSERT, 32'sh80000000);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd1);
    repeat (6) send_word(OP_POP, 32'shffffffff);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, -32'sd3);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sh80000000);
    send_word(OP_INSERT, 32'sh55aa33cc);
    repeat (7) send_word(OP_POP, 32'sh5a5a5a5a);

    run_mixed(100, 70);
    run_mixed(100, 50);
    run_mixed(100, 30);
    run_mixed(150, 60);
    run_mixed(150, 40);

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_rsp == 0) begin
      $display("min_priority_queue_core regression: pass");
    end else begin
      $display("min_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule
